### src/rti_pkg.sv
`default_nettype none
package rti_pkg;

    localparam int WINDOW_DEFAULT     = 32;
    localparam int RSI_PERIOD_DEFAULT = 14;

    localparam logic [22:0] RSI_TOP  = 23'd6553600;
    localparam logic [22:0] RSI_HALF = 23'd3276800;
    localparam logic [31:0] RATIO_ONE = 32'd65536;
    localparam logic [31:0] RET_MAX   = 32'h7FFF_FFFF;

    // Front-end record of a classified item.
    typedef struct packed {
        logic        ok;
        logic [30:0] price;
        logic [30:0] vol;
    } tick_t;

    // Squared Q8.24 magnitude, rescaled to Q.24.
    function automatic logic [39:0] sq_q24(input logic [31:0] mag);
        logic [63:0] p;
        p = {32'd0, mag} * {32'd0, mag};
        return p[63:24];
    endfunction

endpackage
`default_nettype wire

### src/rolling_tick_indicators.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | bid, ask, last_price, volume
// out     | output    | out_valid/out_stall| accepted .. previous_price
// An accepted tick holds the back end from pop to release, its steps set by the
// shared iterative divide/square-root unit: return, volume ratio, mean, variance,
// root, RSI. The first tick and a tick with a zero loss sum each skip one division.
// A rejected tick goes from idle straight to the result wait state.
// Reset is asynchronous and active low; no clearing pass is needed.
// The output stall holds the result and the back end; the two-entry queue keeps
// accepting until it is full, then stalls the input.
`default_nettype none
module rolling_tick_indicators #(
    parameter int WINDOW     = rti_pkg::WINDOW_DEFAULT,
    parameter int RSI_PERIOD = rti_pkg::RSI_PERIOD_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] bid,
    input  wire logic signed [31:0] ask,
    input  wire logic signed [31:0] last_price,
    input  wire logic signed [31:0] volume,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    accepted,
    output logic                    ready_res,
    output logic [22:0]             rsi,
    output logic signed [31:0]      momentum,
    output logic [31:0]             relative_volume,
    output logic [30:0]             volatility,
    output logic [30:0]             chosen_price,
    output logic [30:0]             tick_volume,
    output logic [30:0]             previous_price
);
    import rti_pkg::*;

    logic  q_valid, q_pop;
    tick_t q_data;

    rti_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .bid(bid), .ask(ask), .last_price(last_price), .volume(volume),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

    rti_back #(.WINDOW(WINDOW), .RSI_PERIOD(RSI_PERIOD)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
        .out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
        .ready_res(ready_res), .rsi(rsi), .momentum(momentum),
        .relative_volume(relative_volume), .volatility(volatility),
        .chosen_price(chosen_price), .tick_volume(tick_volume),
        .previous_price(previous_price));
endmodule
`default_nettype wire

### src/rti_ram.sv
`default_nettype none
module rti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/rti_front.sv
`default_nettype none
module rti_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [31:0]  bid,
    input  wire logic signed [31:0]  ask,
    input  wire logic signed [31:0]  last_price,
    input  wire logic signed [31:0]  volume,
    output logic                     q_valid,
    output rti_pkg::tick_t           q_data,
    input  wire logic                q_pop
);
    import rti_pkg::*;

    localparam int QD = 2;

    tick_t       q_reg [QD];
    logic [0:0]  rd_reg, wr_reg;
    logic [1:0]  cnt_reg;
    tick_t       cls;
    logic signed [32:0] mid;
    logic signed [31:0] price;
    logic        push;

    // Price choice and rejection test.
    always_comb
    begin
        mid = (33'(bid) + 33'(ask)) >>> 1;
        if (bid > 0 && ask > 0 && ask >= bid)
        begin
            price = mid[31:0];
        end
        else
        begin
            price = last_price;
        end
        cls.ok    = (price > 0) && !volume[31];
        cls.price = price[30:0];
        cls.vol   = volume[30:0];
    end

    assign in_stall = (cnt_reg == 2'(QD));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = q_reg[rd_reg];

    // Short queue to the back end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QD))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> q_valid)
        else $error("input stalled with an empty queue");
endmodule
`default_nettype wire

### src/rti_div.sv
`default_nettype none
module rti_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        is_sqrt,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic             busy,
    output logic [63:0]      quo
);
    // Restoring divider or bit-pair square root, one result bit per cycle.
    logic [63:0] n_reg, d_reg, q_reg, r_reg;
    logic        sq_reg;
    logic [6:0]  cnt_reg;
    logic [65:0] rs, trial;

    assign busy = (cnt_reg != 7'd0);
    assign quo  = q_reg;

    always_comb
    begin
        if (sq_reg)
        begin
            rs    = {r_reg, n_reg[63:62]};
            trial = rs - {q_reg, 2'b01};
        end
        else
        begin
            rs    = {1'b0, r_reg, n_reg[63]};
            trial = rs - {2'b00, d_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= is_sqrt ? 7'd32 : 7'd64;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg  <= num;
            d_reg  <= den;
            q_reg  <= '0;
            r_reg  <= '0;
            sq_reg <= is_sqrt;
        end
        else if (busy)
        begin
            n_reg <= sq_reg ? {n_reg[61:0], 2'b00} : {n_reg[62:0], 1'b0};
            if (!trial[65])
            begin
                r_reg <= trial[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= rs[63:0];
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

### src/rti_back.sv
`default_nettype none
module rti_back #(
    parameter int WINDOW     = rti_pkg::WINDOW_DEFAULT,
    parameter int RSI_PERIOD = rti_pkg::RSI_PERIOD_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  rti_pkg::tick_t   q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic             ready_res,
    output logic [22:0]      rsi,
    output logic signed [31:0] momentum,
    output logic [31:0]      relative_volume,
    output logic [30:0]      volatility,
    output logic [30:0]      chosen_price,
    output logic [30:0]      tick_volume,
    output logic [30:0]      previous_price
);
    import rti_pkg::*;

    localparam int FILL_CAP = (WINDOW > RSI_PERIOD) ? WINDOW : RSI_PERIOD;
    localparam int WB = $clog2(WINDOW);
    localparam int PB = $clog2(RSI_PERIOD);
    localparam int FB = $clog2(FILL_CAP + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RET = 4'd2, S_UPD = 4'd3,
                           S_RAT = 4'd4, S_MEAN = 4'd5, S_VAR = 4'd6, S_SQRT = 4'd7,
                           S_RSI = 4'd8, S_OUT = 4'd9, S_WAIT = 4'd10, S_RD2 = 4'd11;

    logic [3:0]  st_reg;
    logic [WB-1:0] wp_reg;
    logic [PB-1:0] pp_reg;
    logic [FB-1:0] fill_reg;
    logic [30:0] held_reg, price_reg, vol_reg, prev_reg;
    logic [39:0] vsum_reg, gsum_reg, lsum_reg;
    logic signed [39:0] rsum_reg;
    logic [55:0] sqsum_reg;
    logic signed [31:0] ret_reg;
    logic [31:0] gain_reg, loss_reg;
    logic [63:0] ratio_reg, msq_reg;
    logic        neg_reg;

    // Divider control.
    logic        d_start, d_sqrt, d_busy;
    logic [63:0] d_num, d_den, d_q;

    // Ring memories.
    logic        r_we;
    logic [31:0] rr_q, vr_q, gr_q, lr_q;

    rti_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_ret (
        .clk(clk), .we(r_we), .waddr(wp_reg), .wdata(ret_reg),
        .raddr(wp_reg), .rdata(rr_q));
    rti_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_vol (
        .clk(clk), .we(r_we), .waddr(wp_reg), .wdata({1'b0, vol_reg}),
        .raddr(wp_reg), .rdata(vr_q));
    rti_ram #(.WIDTH(32), .DEPTH(RSI_PERIOD)) u_gain (
        .clk(clk), .we(r_we), .waddr(pp_reg), .wdata(gain_reg),
        .raddr(pp_reg), .rdata(gr_q));
    rti_ram #(.WIDTH(32), .DEPTH(RSI_PERIOD)) u_loss (
        .clk(clk), .we(r_we), .waddr(pp_reg), .wdata(loss_reg),
        .raddr(pp_reg), .rdata(lr_q));

    rti_div u_div (
        .clk(clk), .rst_n(rst_n), .start(d_start), .is_sqrt(d_sqrt),
        .num(d_num), .den(d_den), .busy(d_busy), .quo(d_q));

    logic [FB-1:0] n_win, n_new;
    logic [46+FB:0] rat_num;
    logic [31:0]   rr_mag, diff_mag;
    logic signed [32:0] diff;
    logic [63:0]   mean_mag;

    assign n_win  = (fill_reg < FB'(WINDOW)) ? fill_reg : FB'(WINDOW);
    // Window count once the current tick is included.
    assign n_new  = (fill_reg < FB'(WINDOW)) ? fill_reg + 1'b1 : FB'(WINDOW);
    assign rat_num = {vol_reg, 16'd0} * n_new;
    assign rr_mag = rr_q[31] ? 32'(-rr_q) : rr_q;
    assign diff   = 33'(price_reg) - 33'(prev_reg);
    assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
    assign mean_mag = d_q;

    assign q_pop = (st_reg == S_IDLE) && q_valid;
    assign out_valid = (st_reg == S_WAIT);

    // Divider operand selection by step.
    always_comb
    begin
        d_start = 1'b0;
        d_sqrt  = 1'b0;
        d_num   = '0;
        d_den   = 64'd1;
        case (st_reg)
            S_RD2:
            begin
                d_start = (fill_reg != '0);
                d_num   = {8'd0, diff_mag, 24'd0};
                d_den   = {33'd0, prev_reg};
            end
            S_UPD:
            begin
                d_start = 1'b1;
                d_num   = 64'(rat_num);
                d_den   = 64'(vsum_reg + 40'(vol_reg) - ((fill_reg >= FB'(WINDOW)) ? 40'(vr_q) : 40'd0));
                if (d_den == 64'd0) d_den = 64'd1;
            end
            S_RAT:
            begin
                d_start = !d_busy;
                d_num   = rsum_reg[39] ? 64'(-rsum_reg) : 64'(rsum_reg);
                d_den   = 64'(n_win);
            end
            S_MEAN:
            begin
                d_start = !d_busy;
                d_num   = 64'(sqsum_reg);
                d_den   = 64'(n_win);
            end
            S_VAR:
            begin
                d_start = !d_busy;
                d_sqrt  = 1'b1;
                d_num   = ((d_q > msq_reg) ? (d_q - msq_reg) : 64'd0) << 24;
            end
            S_SQRT:
            begin
                d_start = !d_busy && (lsum_reg != '0);
                d_num   = {24'd0, gsum_reg} * 64'(RSI_TOP);
                d_den   = 64'(gsum_reg) + 64'(lsum_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            wp_reg    <= '0;
            pp_reg    <= '0;
            fill_reg  <= '0;
            held_reg  <= '0;
            vsum_reg  <= '0;
            rsum_reg  <= '0;
            sqsum_reg <= '0;
            gsum_reg  <= '0;
            lsum_reg  <= '0;
            r_we      <= 1'b0;
        end
        else
        begin
            r_we <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        price_reg <= q_data.price;
                        vol_reg   <= q_data.vol;
                        prev_reg  <= (fill_reg == '0) ? q_data.price : held_reg;
                        if (q_data.ok)
                        begin
                            st_reg <= S_RD;
                        end
                        else
                        begin
                            accepted <= 1'b0;
                            ready_res <= 1'b0;
                            rsi <= '0; momentum <= '0; relative_volume <= '0;
                            volatility <= '0; chosen_price <= '0;
                            tick_volume <= '0; previous_price <= '0;
                            st_reg <= S_WAIT;
                        end
                    end
                end
                S_RD:
                begin
                    // Ring outputs settle this cycle.
                    gain_reg <= diff[32] ? 32'd0 : diff[31:0];
                    loss_reg <= diff_mag & {32{diff[32]}};
                    neg_reg  <= diff[32];
                    st_reg   <= S_RD2;
                end
                S_RD2:
                begin
                    st_reg <= S_RET;
                end
                S_RET:
                begin
                    if (!d_busy)
                    begin
                        if (fill_reg == '0)
                        begin
                            ret_reg <= '0;
                        end
                        else if (neg_reg)
                        begin
                            ret_reg <= 32'(-d_q);
                        end
                        else
                        begin
                            ret_reg <= (d_q > 64'(RET_MAX)) ? RET_MAX : d_q[31:0];
                        end
                        st_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    // Slide sums: add the new entry and, once the window is full, drop the leaving one.
                    if (fill_reg >= FB'(WINDOW))
                    begin
                        vsum_reg  <= vsum_reg + 40'(vol_reg) - 40'(vr_q);
                        rsum_reg  <= rsum_reg + 40'(ret_reg) - 40'($signed(rr_q));
                        sqsum_reg <= sqsum_reg + 56'(sq_q24(ret_reg[31] ? 32'(-ret_reg) : ret_reg))
                                     - 56'(sq_q24(rr_mag));
                    end
                    else
                    begin
                        vsum_reg  <= vsum_reg + 40'(vol_reg);
                        rsum_reg  <= rsum_reg + 40'(ret_reg);
                        sqsum_reg <= sqsum_reg + 56'(sq_q24(ret_reg[31] ? 32'(-ret_reg) : ret_reg));
                    end
                    if (fill_reg >= FB'(RSI_PERIOD))
                    begin
                        gsum_reg <= gsum_reg + 40'(gain_reg) - 40'(gr_q);
                        lsum_reg <= lsum_reg + 40'(loss_reg) - 40'(lr_q);
                    end
                    else
                    begin
                        gsum_reg <= gsum_reg + 40'(gain_reg);
                        lsum_reg <= lsum_reg + 40'(loss_reg);
                    end
                    r_we     <= 1'b1;
                    held_reg <= price_reg;
                    if (fill_reg < FB'(FILL_CAP))
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    st_reg <= S_RAT;
                end
                S_RAT:
                begin
                    if (!d_busy)
                    begin
                        wp_reg <= (32'(wp_reg) + 1 >= WINDOW) ? '0 : wp_reg + 1'b1;
                        pp_reg <= (32'(pp_reg) + 1 >= RSI_PERIOD) ? '0 : pp_reg + 1'b1;
                        if (vsum_reg == '0) ratio_reg <= 64'(RATIO_ONE);
                        else ratio_reg <= (d_q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d_q;
                        st_reg <= S_MEAN;
                    end
                end
                S_MEAN:
                begin
                    if (!d_busy)
                    begin
                        msq_reg <= 64'(sq_q24(mean_mag[31:0]));
                        st_reg  <= S_VAR;
                    end
                end
                S_VAR:
                begin
                    if (!d_busy)
                    begin
                        st_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (!d_busy)
                    begin
                        volatility <= (d_q > 64'(RET_MAX)) ? RET_MAX[30:0] : d_q[30:0];
                        st_reg <= S_RSI;
                    end
                end
                S_RSI:
                begin
                    if (!d_busy)
                    begin
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    accepted <= 1'b1;
                    ready_res <= (fill_reg >= FB'(RSI_PERIOD));
                    if (lsum_reg != '0) rsi <= d_q[22:0];
                    else if (gsum_reg != '0) rsi <= RSI_TOP;
                    else rsi <= RSI_HALF;
                    momentum <= ret_reg;
                    relative_volume <= ratio_reg[31:0];
                    chosen_price <= price_reg;
                    tick_volume <= vol_reg;
                    previous_price <= prev_reg;
                    st_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!out_stall)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) r_we |-> $past(st_reg) == S_UPD)
        else $error("ring write outside update step");
    assert property (@(posedge clk) disable iff (!rst_n) (q_pop && q_data.ok) |=> !out_valid)
        else $error("result shown while taking an item");
    assert property (@(posedge clk) disable iff (!rst_n) 32'(fill_reg) <= FILL_CAP)
        else $error("fill count past cap");
endmodule
`default_nettype wire

### tb/rti_checker.sv
`default_nettype none
module rti_checker #(
    parameter int WINDOW     = 32,
    parameter int RSI_PERIOD = 14
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic signed [31:0] bid,
    input  wire logic signed [31:0] ask,
    input  wire logic signed [31:0] last_price,
    input  wire logic signed [31:0] volume,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic               accepted,
    input  wire logic               ready_res,
    input  wire logic [22:0]        rsi,
    input  wire logic signed [31:0] momentum,
    input  wire logic [31:0]        relative_volume,
    input  wire logic [30:0]        volatility,
    input  wire logic [30:0]        chosen_price,
    input  wire logic [30:0]        tick_volume,
    input  wire logic [30:0]        previous_price,
    output int                      fail_count,
    output int                      pending_count,
    output int                      result_count
);

    localparam int FILL_CAP = (WINDOW > RSI_PERIOD) ? WINDOW : RSI_PERIOD;

    typedef struct packed {
        logic        accepted;
        logic        ready_res;
        logic [22:0] rsi;
        logic [31:0] momentum;
        logic [31:0] relative_volume;
        logic [30:0] volatility;
        logic [30:0] chosen_price;
        logic [30:0] tick_volume;
        logic [30:0] previous_price;
    } indicator_t;

    indicator_t indicator_queue[$];

    // Shadow state of the indicator engine.
    longint    ret_hist[WINDOW];
    longint    vol_hist[WINDOW];
    longint    gain_hist[RSI_PERIOD];
    longint    loss_hist[RSI_PERIOD];
    longint    vol_total;
    longint    ret_total;
    longint unsigned sq_total;
    longint    gain_total;
    longint    loss_total;
    int        win_idx;
    int        per_idx;
    int        ticks_seen;
    longint    last_held;

    function automatic longint unsigned square_q24(longint r);
        longint unsigned m;
        m = (r < 0) ? longint'(-r) : longint'(r);
        return (m * m) >> 24;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Compute the indicators for one tick and, if it is accepted, advance the shadow state.
    function automatic indicator_t predict_indicators(longint b, longint a, longint lp,
                                                      longint v);
        indicator_t r;
        longint price, prev, diff, ret, mean, n;
        longint unsigned gain, loss, mag, q, ratio, var_v, msq, rsi_v;
        r = '0;
        if (b > 0 && a > 0 && a >= b)
            price = (b + a) >>> 1;
        else
            price = lp;
        if (price <= 0 || v < 0)
            return r;
        prev = (ticks_seen == 0) ? price : last_held;
        diff = price - prev;
        gain = (diff > 0) ? diff : 0;
        loss = (diff < 0) ? -diff : 0;
        ret = 0;
        if (ticks_seen > 0 && prev > 0)
        begin
            mag = (diff < 0) ? -diff : diff;
            q = (mag << 24) / longint'(prev);
            if (diff < 0)
                ret = -longint'(q);
            else
                ret = (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
        end
        if (ticks_seen >= WINDOW)
        begin
            vol_total -= vol_hist[win_idx];
            ret_total -= ret_hist[win_idx];
            sq_total -= square_q24(ret_hist[win_idx]);
        end
        if (ticks_seen >= RSI_PERIOD)
        begin
            gain_total -= gain_hist[per_idx];
            loss_total -= loss_hist[per_idx];
        end
        vol_hist[win_idx] = v;
        ret_hist[win_idx] = ret;
        gain_hist[per_idx] = gain;
        loss_hist[per_idx] = loss;
        vol_total += v;
        ret_total += ret;
        sq_total += square_q24(ret);
        gain_total += gain;
        loss_total += loss;
        win_idx = (win_idx + 1 >= WINDOW) ? 0 : win_idx + 1;
        per_idx = (per_idx + 1 >= RSI_PERIOD) ? 0 : per_idx + 1;
        if (ticks_seen < FILL_CAP) ticks_seen++;
        n = (ticks_seen < WINDOW) ? ticks_seen : WINDOW;
        if (vol_total > 0)
        begin
            ratio = ((longint'(v) * n) << 16) / longint'(vol_total);
            if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
        end
        else
            ratio = 65536;
        mean = ret_total / n;
        msq = square_q24(mean);
        var_v = sq_total / longint'(n);
        var_v = (var_v > msq) ? var_v - msq : 0;
        var_v = int_sqrt(var_v << 24);
        if (var_v > 64'h7FFF_FFFF) var_v = 64'h7FFF_FFFF;
        if (loss_total == 0 && gain_total > 0)
            rsi_v = 64'd100 << 16;
        else if (loss_total > 0)
            rsi_v = ((64'd100 << 16) * gain_total) / longint'(gain_total + loss_total);
        else
            rsi_v = 64'd50 << 16;
        last_held = price;
        r.accepted = 1'b1;
        r.ready_res = (ticks_seen >= RSI_PERIOD);
        r.rsi = rsi_v[22:0];
        r.momentum = ret[31:0];
        r.relative_volume = ratio[31:0];
        r.volatility = var_v[30:0];
        r.chosen_price = price[30:0];
        r.tick_volume = v[30:0];
        r.previous_price = prev[30:0];
        return r;
    endfunction

    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        result_count = 0;
        vol_total = 0;
        ret_total = 0;
        sq_total = 0;
        gain_total = 0;
        loss_total = 0;
        win_idx = 0;
        per_idx = 0;
        ticks_seen = 0;
        last_held = 0;
    end

    assign pending_count = indicator_queue.size();

    // Predict on each tick taken at the input and check each delivered result.
    always @(posedge clk)
    begin
        indicator_t e;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                indicator_queue.push_back(predict_indicators(bid, ask, last_price, volume));
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (indicator_queue.size() == 0)
                begin
                    $error("result with no tick outstanding");
                    fail_count++;
                end
                else
                begin
                    e = indicator_queue.pop_front();
                    compare_field("accepted", e.accepted, accepted);
                    compare_field("ready_res", e.ready_res, ready_res);
                    compare_field("rsi", e.rsi, rsi);
                    compare_field("momentum", signed'(e.momentum), momentum);
                    compare_field("relative_volume", e.relative_volume, relative_volume);
                    compare_field("volatility", e.volatility, volatility);
                    compare_field("chosen_price", e.chosen_price, chosen_price);
                    compare_field("tick_volume", e.tick_volume, tick_volume);
                    compare_field("previous_price", e.previous_price, previous_price);
                end
            end
        end
    end

endmodule
`default_nettype wire

### tb/rolling_tick_indicators_tb.sv
`default_nettype none
module rolling_tick_indicators_tb;

    localparam int  RANDOM_TICKS = 830;
    localparam longint CYCLE_LIMIT = 1_500_000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] bid;
    logic signed [31:0] ask;
    logic signed [31:0] last_price;
    logic signed [31:0] volume;
    logic               out_valid;
    logic               out_stall;
    logic               accepted;
    logic               ready_res;
    logic [22:0]        rsi;
    logic signed [31:0] momentum;
    logic [31:0]        relative_volume;
    logic [30:0]        volatility;
    logic [30:0]        chosen_price;
    logic [30:0]        tick_volume;
    logic [30:0]        previous_price;
    int                 fail_count;
    int                 pending_count;
    int                 result_count;
    longint             cycle_count;
    int                 sent_count;
    logic               calm_phase;
    logic               hold_off;
    logic [31:0]        base_price;

    rolling_tick_indicators i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .bid(bid), .ask(ask), .last_price(last_price), .volume(volume),
        .out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
        .ready_res(ready_res), .rsi(rsi), .momentum(momentum),
        .relative_volume(relative_volume), .volatility(volatility),
        .chosen_price(chosen_price), .tick_volume(tick_volume),
        .previous_price(previous_price)
    );

    rti_checker i_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .bid(bid), .ask(ask), .last_price(last_price), .volume(volume),
        .out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
        .ready_res(ready_res), .rsi(rsi), .momentum(momentum),
        .relative_volume(relative_volume), .volatility(volatility),
        .chosen_price(chosen_price), .tick_volume(tick_volume),
        .previous_price(previous_price), .fail_count(fail_count),
        .pending_count(pending_count), .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on total run length.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("rolling_tick_indicators_tb: errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, a calm stretch, and one long hold-off.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (calm_phase)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 28);
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (sent_count >= 300);
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
    end

    // Offer one item and wait until it is taken.
    task automatic send_tick(logic [31:0] b, logic [31:0] a, logic [31:0] lp,
                             logic [31:0] v);
        while (!calm_phase && !hold_off && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        bid <= b;
        ask <= a;
        last_price <= lp;
        volume <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
    endtask

    // Mostly realistic ticks around a drifting price, with some noise.
    task automatic send_random_tick();
        logic [31:0] spread, v;
        int pick;
        pick = $urandom_range(99);
        base_price = base_price + $urandom_range(4000) - 2000;
        if (base_price[31] || base_price < 32'h0001_0000) base_price = 32'h0064_0000;
        spread = $urandom_range(2000);
        v = $urandom_range(32'h00FF_FFFF);
        if (pick < 70)
            send_tick(base_price, base_price + spread, $urandom, v);
        else if (pick < 80)
            send_tick($urandom, $urandom, base_price, v);
        else if (pick < 85)
            send_tick(base_price, base_price, base_price, 0);
        else if (pick < 90)
            send_tick($urandom & 32'h7FFF_FFFF, $urandom & 32'h7FFF_FFFF,
                      $urandom & 32'h7FFF_FFFF, $urandom & 32'h7FFF_FFFF);
        else
            send_tick($urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        bid = '0;
        ask = '0;
        last_price = '0;
        volume = '0;
        calm_phase = 1'b0;
        sent_count = 0;
        base_price = 32'h0064_0000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first tick, rejections, extremes, midpoint and fallback.
        send_tick(32'h0064_0000, 32'h0064_8000, 0, 32'h0001_0000);
        send_tick(0, 0, 0, 32'h0001_0000);
        send_tick(32'h0064_0000, 32'h0065_0000, 0, 32'hFFFF_FFFF);
        send_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF);
        send_tick(32'h0000_0001, 32'h0000_0001, 32'h1, 0);
        send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 0);
        send_tick(32'h0065_0000, 32'h0064_0000, 32'h0050_0000, 32'h0002_0000);
        send_tick(32'hFFFF_0000, 32'h0064_0000, 32'h0060_0000, 0);
        send_tick(32'h0064_0000, 32'hFFFF_0000, 32'h0070_0000, 32'h0001_0000);
        send_tick(0, 32'h0064_0000, 32'hFFFF_FFFF, 32'h0001_0000);
        for (int k = 0; k < 8; k++)
            send_tick(32'h0064_0000 + k * 32'h1_0000, 32'h0064_0000 + k * 32'h1_0000,
                      0, 32'h0001_0000);

        // Random ticks, with a stretch without any idling.
        for (int k = 0; k < RANDOM_TICKS; k++)
        begin
            calm_phase <= (k >= 500 && k < 600);
            send_random_tick();
        end
        in_valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Sent %0d ticks, checked %0d results, incl. rejects and a long output hold-off.",
                 sent_count, result_count);
        if (fail_count == 0)
            $display("rolling_tick_indicators_tb: clean");
        else
            $display("rolling_tick_indicators_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
src/rti_pkg.sv
src/rti_ram.sv
src/rti_front.sv
src/rti_div.sv
src/rti_back.sv
src/rolling_tick_indicators.sv
tb/rti_checker.sv
tb/rolling_tick_indicators_tb.sv
